FILE: sv/xysd_pkg.sv
// Package for the X/Y stillness detector: sizes, opcodes, register indexes,
// transaction structs and controller states. No dependencies.
`default_nettype none

package xysd_pkg;

  // Bucket store sizing
  localparam int NUM_BUCKETS = 32;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);

  localparam int METRIC_W = 17;
  localparam int PADDR_W  = 5;
  localparam logic [7:0] QUIET_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_BEGIN    = 2'd1,
    OP_FINISH   = 2'd2,
    OP_FALLBACK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MAX_GAP    = 3'd0,
    REG_BUCKET_MS  = 3'd1,
    REG_MIN_BUCKET = 3'd2,
    REG_MOVE_LIMIT = 3'd3,
    REG_MARGIN     = 3'd4,
    REG_STILL_MIN  = 3'd5,
    REG_STILL_MAX  = 3'd6,
    REG_FALLBACK   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          quiet_count;
    logic [METRIC_W-1:0] last_metric;
    logic [METRIC_W-1:0] still_threshold;
    logic [METRIC_W-1:0] peak_metric;
    logic                calib_ok;
    logic [5:0]          bucket_count;
    logic                calib_active;
  } out_item_t;

  typedef struct packed {
    logic [15:0]         max_gap_ms;
    logic [15:0]         bucket_ms;
    logic [5:0]          min_buckets;
    logic [METRIC_W-1:0] move_limit;
    logic [15:0]         still_margin;
    logic [METRIC_W-1:0] still_min;
    logic [METRIC_W-1:0] still_max;
    logic [METRIC_W-1:0] fallback_threshold;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] remainder;
  } rem_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN_START,
    ST_FIN_CRD,
    ST_FIN_CLAT,
    ST_FIN_SRD,
    ST_FIN_SCMP,
    ST_FIN_EVAL,
    ST_FIN_CHECK,
    ST_FIN_CLAMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/xysd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module xysd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/xysd_rem.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on xysd_pkg for the request and response structs.
`default_nettype none

module xysd_rem
  import xysd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rem_req_t req,
  output rem_rsp_t      rsp
);

  logic [16:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  // Shift in one dividend bit and subtract where it fits
  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], dvd_r[31]};
    if (req.start && !busy_r) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dvs_r}) ? trial - {1'b0, dvs_r} : trial;
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp = {busy_r, done_r, rem_r[15:0]};

endmodule

`default_nettype wire

FILE: sv/xysd_cfg.sv
// APB-style configuration register file for the stillness detector.
// Depends on xysd_pkg for register indexes and the configuration struct.
`default_nettype none

module xysd_cfg
  import xysd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write the addressed register on the access cycle
  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_MAX_GAP:    cfg_nxt.max_gap_ms         = pwdata[15:0];
        REG_BUCKET_MS:  cfg_nxt.bucket_ms          = pwdata[15:0];
        REG_MIN_BUCKET: cfg_nxt.min_buckets        = pwdata[5:0];
        REG_MOVE_LIMIT: cfg_nxt.move_limit         = pwdata[METRIC_W-1:0];
        REG_MARGIN:     cfg_nxt.still_margin       = pwdata[15:0];
        REG_STILL_MIN:  cfg_nxt.still_min          = pwdata[METRIC_W-1:0];
        REG_STILL_MAX:  cfg_nxt.still_max          = pwdata[METRIC_W-1:0];
        REG_FALLBACK:   cfg_nxt.fallback_threshold = pwdata[METRIC_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_MAX_GAP:    prdata = {16'd0, cfg_r.max_gap_ms};
      REG_BUCKET_MS:  prdata = {16'd0, cfg_r.bucket_ms};
      REG_MIN_BUCKET: prdata = {26'd0, cfg_r.min_buckets};
      REG_MOVE_LIMIT: prdata = {15'd0, cfg_r.move_limit};
      REG_MARGIN:     prdata = {16'd0, cfg_r.still_margin};
      REG_STILL_MIN:  prdata = {15'd0, cfg_r.still_min};
      REG_STILL_MAX:  prdata = {15'd0, cfg_r.still_max};
      REG_FALLBACK:   prdata = {15'd0, cfg_r.fallback_threshold};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_gap_ms         <= 16'd100;
      cfg_r.bucket_ms          <= 16'd1000;
      cfg_r.min_buckets        <= 6'd5;
      cfg_r.move_limit         <= 17'd512;
      cfg_r.still_margin       <= 16'd384;
      cfg_r.still_min          <= 17'd13;
      cfg_r.still_max          <= 17'd256;
      cfg_r.fallback_threshold <= 17'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/xy_stillness_detector_core.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_item_t (opcode, accel, time)
// out_      output     out_valid / out_ready  out_item_t (counters, threshold)
// config    input      psel/penable/pwrite    8 registers, 32-bit APB data
//
// Begin, fallback and plain samples pass through the execute and done states;
// a sample that closes a bucket also waits on the bit-serial remainder unit.
// Finish scans the bucket RAM through its single read port, once per candidate,
// to find the median of the recorded buckets.
// Reset is synchronous and needs no clearing pass. A stalled output holds
// the controller in its done state; one item is in flight at a time.
// Depends on xysd_pkg, xysd_ram, xysd_rem and xysd_cfg.
`default_nettype none

module xy_stillness_detector_core
  import xysd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t     cfg;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  state_t   state_r, state_nxt;
  in_item_t item_r, item_nxt;

  logic signed [15:0]  prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [31:0]         prev_time_r, prev_time_nxt;
  logic                have_prev_r, have_prev_nxt;
  logic [METRIC_W-1:0] metric_r, metric_nxt;
  logic [7:0]          quiet_r, quiet_nxt;
  logic                calib_r, calib_nxt;
  logic [31:0]         bbegin_r, bbegin_nxt;
  logic [METRIC_W-1:0] bpeak_r, bpeak_nxt;
  logic                touched_r, touched_nxt;
  logic [METRIC_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [METRIC_W-1:0] thr_r, thr_nxt;
  logic                ok_r, ok_nxt;

  logic [IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0]    lt_r, lt_nxt, le_r, le_nxt;
  logic [METRIC_W-1:0] cand_r, cand_nxt, max_r, max_nxt, med_r, med_nxt;
  logic [32:0]         prod_r, prod_nxt;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  logic [METRIC_W-1:0] ram_rdata;

  // Sample datapath
  logic signed [16:0]  dx, dy;
  logic [16:0]         adx, ady;
  logic [17:0]         msum;
  logic [METRIC_W-1:0] m;
  logic [31:0]         dt, diff;
  logic [15:0]         blen;
  logic                rec_ok;
  logic [CNT_W-1:0]    last_n, med_k;
  logic [24:0]         pscaled;

  assign dx   = 17'(item_r.accel_x) - 17'(prev_x_r);
  assign dy   = 17'(item_r.accel_y) - 17'(prev_y_r);
  assign adx  = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady  = dy[16] ? 17'(-dy) : 17'(dy);
  assign msum = {1'b0, adx} + {1'b0, ady};
  assign m    = msum[METRIC_W-1:0];
  assign dt   = item_r.time_ms - prev_time_r;
  assign diff = item_r.time_ms - bbegin_r;
  assign blen = (cfg.bucket_ms == 16'd0) ? 16'd1 : cfg.bucket_ms;
  assign rec_ok = touched_r && (total_r < CNT_W'(NUM_BUCKETS));
  assign last_n = total_r - CNT_W'(1);
  assign med_k  = last_n >> 1;
  assign pscaled = prod_r[32:8];

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  xysd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xysd_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  xysd_ram #(.WIDTH(METRIC_W), .DEPTH(NUM_BUCKETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total_r[IDX_W-1:0]),
    .wdata (bpeak_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_time_nxt = prev_time_r;
    have_prev_nxt = have_prev_r;
    metric_nxt    = metric_r;
    quiet_nxt     = quiet_r;
    calib_nxt     = calib_r;
    bbegin_nxt    = bbegin_r;
    bpeak_nxt     = bpeak_r;
    touched_nxt   = touched_r;
    peak_nxt      = peak_r;
    total_nxt     = total_r;
    thr_nxt       = thr_r;
    ok_nxt        = ok_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lt_nxt        = lt_r;
    le_nxt        = le_r;
    cand_nxt      = cand_r;
    max_nxt       = max_r;
    med_nxt       = med_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_raddr     = j_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = diff;
    rem_req.divisor  = blen;

    // Drop the output transaction once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        ok_nxt    = 1'b0;
        state_nxt = ST_DONE;
        case (item_r.opcode)
          OP_SAMPLE: begin
            prev_x_nxt    = item_r.accel_x;
            prev_y_nxt    = item_r.accel_y;
            prev_time_nxt = item_r.time_ms;
            have_prev_nxt = 1'b1;
            if (have_prev_r && dt != 32'd0 && dt <= {16'd0, cfg.max_gap_ms}) begin
              metric_nxt = m;
              if (thr_r != '0) begin
                if (m < thr_r) begin
                  quiet_nxt = (quiet_r != QUIET_MAX) ? quiet_r + 8'd1 : quiet_r;
                end else begin
                  quiet_nxt = '0;
                end
              end
              if (calib_r) begin
                if (diff >= {16'd0, blen}) begin
                  rem_req.start = 1'b1;
                  state_nxt     = ST_DIV;
                end else if (!touched_r || m > bpeak_r) begin
                  bpeak_nxt   = m;
                  touched_nxt = 1'b1;
                end
              end
            end
          end
          OP_BEGIN: begin
            calib_nxt     = 1'b1;
            bbegin_nxt    = item_r.time_ms;
            bpeak_nxt     = '0;
            touched_nxt   = 1'b0;
            peak_nxt      = '0;
            total_nxt     = '0;
            thr_nxt       = '0;
            quiet_nxt     = '0;
            have_prev_nxt = 1'b0;
          end
          OP_FINISH: begin
            calib_nxt = 1'b0;
            if (rec_ok) begin
              ram_we    = 1'b1;
              total_nxt = total_r + CNT_W'(1);
            end
            state_nxt = ST_FIN_START;
          end
          default: begin
            calib_nxt = 1'b0;
            thr_nxt   = cfg.fallback_threshold;
            quiet_nxt = '0;
          end
        endcase
      end

      // Close the bucket: record it if touched and not full, realign start to the grid
      ST_DIV: begin
        if (rem_rsp.done) begin
          if (rec_ok) begin
            ram_we    = 1'b1;
            total_nxt = total_r + CNT_W'(1);
          end
          bbegin_nxt  = item_r.time_ms - {16'd0, rem_rsp.remainder};
          bpeak_nxt   = metric_r;
          touched_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end
      end

      ST_FIN_START: begin
        i_nxt   = '0;
        max_nxt = '0;
        med_nxt = '0;
        state_nxt = (total_r == '0) ? ST_DONE : ST_FIN_CRD;
      end

      ST_FIN_CRD: begin
        ram_raddr = i_r;
        state_nxt = ST_FIN_CLAT;
      end

      ST_FIN_CLAT: begin
        cand_nxt  = ram_rdata;
        max_nxt   = (ram_rdata > max_r) ? ram_rdata : max_r;
        lt_nxt    = '0;
        le_nxt    = '0;
        j_nxt     = '0;
        state_nxt = ST_FIN_SRD;
      end

      ST_FIN_SRD: begin
        ram_raddr = j_r;
        state_nxt = ST_FIN_SCMP;
      end

      // Count entries below and at the candidate
      ST_FIN_SCMP: begin
        if (ram_rdata < cand_r) begin
          lt_nxt = lt_r + CNT_W'(1);
        end
        if (ram_rdata <= cand_r) begin
          le_nxt = le_r + CNT_W'(1);
        end
        if (CNT_W'(j_r) == last_n) begin
          state_nxt = ST_FIN_EVAL;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_FIN_SRD;
        end
      end

      ST_FIN_EVAL: begin
        if (lt_r <= med_k && med_k < le_r) begin
          med_nxt = cand_r;
        end
        if (CNT_W'(i_r) == last_n) begin
          state_nxt = ST_FIN_CHECK;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_FIN_CRD;
        end
      end

      ST_FIN_CHECK: begin
        peak_nxt = max_r;
        prod_nxt = 33'(med_r) * 33'(cfg.still_margin);
        if (total_r < cfg.min_buckets[CNT_W-1:0] || cfg.min_buckets > 6'(total_r)
            || max_r > cfg.move_limit) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FIN_CLAMP;
        end
      end

      // Clamp low first, then high
      ST_FIN_CLAMP: begin
        if (pscaled < {8'd0, cfg.still_min}) begin
          thr_nxt = cfg.still_min;
        end else if (pscaled > {8'd0, cfg.still_max}) begin
          thr_nxt = cfg.still_max;
        end else begin
          thr_nxt = pscaled[METRIC_W-1:0];
        end
        quiet_nxt = '0;
        ok_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end

      // Hand the transaction over once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.quiet_count     = quiet_r;
          out_data_nxt.last_metric     = metric_r;
          out_data_nxt.still_threshold = thr_r;
          out_data_nxt.peak_metric     = peak_r;
          out_data_nxt.calib_ok        = ok_r;
          out_data_nxt.bucket_count    = 6'(total_r);
          out_data_nxt.calib_active    = calib_r;
          state_nxt                    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_time_r <= '0;
      have_prev_r <= 1'b0;
      metric_r    <= '0;
      quiet_r     <= '0;
      calib_r     <= 1'b0;
      bbegin_r    <= '0;
      bpeak_r     <= '0;
      touched_r   <= 1'b0;
      peak_r      <= '0;
      total_r     <= '0;
      thr_r       <= '0;
      ok_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_time_r <= prev_time_nxt;
      have_prev_r <= have_prev_nxt;
      metric_r    <= metric_nxt;
      quiet_r     <= quiet_nxt;
      calib_r     <= calib_nxt;
      bbegin_r    <= bbegin_nxt;
      bpeak_r     <= bpeak_nxt;
      touched_r   <= touched_nxt;
      peak_r      <= peak_nxt;
      total_r     <= total_nxt;
      thr_r       <= thr_nxt;
      ok_r        <= ok_nxt;
    end
    item_r     <= item_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    lt_r       <= lt_nxt;
    le_r       <= le_nxt;
    cand_r     <= cand_nxt;
    max_r      <= max_nxt;
    med_r      <= med_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(NUM_BUCKETS))
    else $error("bucket count beyond store depth");

  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_EXEC || state_r == ST_DIV))
    else $error("bucket store written outside record phase");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  a_rem_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> state_r == ST_DIV)
    else $error("remainder result arrived outside bucket close");

  a_ok_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && ok_r) |-> !calib_r)
    else $error("calibration still active after a successful finish");
`endif

endmodule

`default_nettype wire
